### sv/bqc_pkg.sv
// Package: widths, register map, control types and arithmetic helpers for the biquad cascade.
package bqc_pkg;

  localparam int SECTIONS  = 3;
  localparam int STATE_W   = 32;
  localparam int SAMPLE_W  = 12;
  localparam int FRAC_W    = 12;
  localparam int COEF_W    = 16;
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int PROD_W    = STATE_W + COEF_W + 1;
  localparam int ACC_W     = STATE_W + 19;
  localparam int ROUND_SH  = 16;
  localparam int W0_W      = ACC_W - ROUND_SH;
  localparam int DIFF_W    = STATE_W + 1;
  localparam int DAC_MAX   = (1 << SAMPLE_W) - 1;

  typedef logic signed [STATE_W-1:0] state_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [W0_W-1:0]    w0_wide_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [COEF_W-1:0]         coef_t;
  typedef logic [REG_IDX_W-1:0]      reg_idx_t;
  typedef logic [SEC_W-1:0]          sec_t;
  typedef logic [SAMPLE_W-1:0]       sample_t;

  localparam acc_t ACC_HALF = acc_t'(1) <<< (ROUND_SH - 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_A1_FIRST,
    REG_A2_FIRST,
    REG_A1_SECOND,
    REG_A2_SECOND,
    REG_A1_THIRD,
    REG_A2_THIRD,
    REG_GAIN_FIRST_TWO,
    REG_GAIN_THIRD
  } reg_idx_e;

  typedef enum logic [1:0] {
    COEF_GAIN,
    COEF_A1,
    COEF_A2
  } coef_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_G,
    ST_MUL_A1,
    ST_MUL_A2,
    ST_SUM,
    ST_WB,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic mul_g;
    logic mul_a1;
    logic mul_a2;
    logic sum;
    logic wb;
    logic emit;
    logic last;
    sec_t sec;
  } bqc_ctl_t;

  typedef struct packed {
    state_t w1;
    state_t w2;
  } delay_row_t;

  function automatic coef_t reg_reset(reg_idx_t idx);
    coef_t v;
    unique case (reg_idx_e'(idx))
      REG_A1_FIRST:       v = coef_t'(-29606);
      REG_A2_FIRST:       v = coef_t'(15620);
      REG_A1_SECOND:      v = coef_t'(-31384);
      REG_A2_SECOND:      v = coef_t'(15906);
      REG_A1_THIRD:       v = coef_t'(-30090);
      REG_A2_THIRD:       v = coef_t'(15157);
      REG_GAIN_FIRST_TWO: v = coef_t'(5031);
      REG_GAIN_THIRD:     v = coef_t'(2453);
      default:            v = '0;
    endcase
    return v;
  endfunction

  // sections past the third reuse the third section's coefficient set
  function automatic reg_idx_t coef_index(sec_t sec, coef_kind_e kind);
    int set_i;
    reg_idx_t idx;
    set_i = (int'(sec) < 3) ? int'(sec) : 2;
    unique case (kind)
      COEF_GAIN: idx = (int'(sec) < 2) ? reg_idx_t'(REG_GAIN_FIRST_TWO)
                                       : reg_idx_t'(REG_GAIN_THIRD);
      COEF_A1:   idx = reg_idx_t'(2 * set_i);
      COEF_A2:   idx = reg_idx_t'(2 * set_i + 1);
      default:   idx = reg_idx_t'(REG_GAIN_THIRD);
    endcase
    return idx;
  endfunction

  function automatic logic ovf_w0(w0_wide_t v);
    return !((&v[W0_W-1:STATE_W-1]) || (~|v[W0_W-1:STATE_W-1]));
  endfunction

  function automatic state_t sat_w0(w0_wide_t v);
    state_t r;
    if (!ovf_w0(v)) begin
      r = v[STATE_W-1:0];
    end else if (v[W0_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic ovf_diff(diff_t v);
    return v[DIFF_W-1] != v[DIFF_W-2];
  endfunction

  function automatic state_t sat_diff(diff_t v);
    state_t r;
    if (!ovf_diff(v)) begin
      r = v[STATE_W-1:0];
    end else if (v[DIFF_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### sv/bqc_if.sv
// Interfaces: sample input channel and filtered output channel with valid/ready.
interface bqc_in_if import bqc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface bqc_out_if import bqc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t dac_code;
  logic    clipped;

  modport source (output valid, output dac_code, output clipped, input ready);
  modport sink (input valid, input dac_code, input clipped, output ready);
endinterface

### sv/bqc_delay_mem.sv
// Delay-pair memory: one row of w1/w2 per section, registered read, zero until written.
module bqc_delay_mem import bqc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  sec_t       rd_addr,
  output delay_row_t rd_data,
  input  logic       wr_en,
  input  sec_t       wr_addr,
  input  delay_row_t wr_data
);

  delay_row_t            mem [SECTIONS];
  logic [SECTIONS-1:0]   row_valid_r;
  delay_row_t            rd_row_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= row_valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_row_r : '0;

endmodule

### sv/bqc_seq.sv
// Sequencer: steps each sample through the sections, three multiplies, a sum and a write-back per section.
module bqc_seq import bqc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_free,
  output logic     in_ready,
  output bqc_ctl_t ctl
);

  seq_state_t state_r, state_nxt;
  sec_t       sec_r, sec_nxt;
  logic       last;

  assign last = (sec_r == sec_t'(SECTIONS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL_G;
          sec_nxt   = '0;
        end
      end
      ST_MUL_G:  state_nxt = ST_MUL_A1;
      ST_MUL_A1: state_nxt = ST_MUL_A2;
      ST_MUL_A2: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_WB;
      ST_WB: begin
        if (last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL_G;
          sec_nxt   = sec_t'(sec_r + 1'b1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl        = '0;
    ctl.sec    = sec_r;
    ctl.last   = last;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.start = in_valid;
      end
      ST_MUL_G:  ctl.mul_g  = 1'b1;
      ST_MUL_A1: ctl.mul_a1 = 1'b1;
      ST_MUL_A2: ctl.mul_a2 = 1'b1;
      ST_SUM:    ctl.sum    = 1'b1;
      ST_WB:     ctl.wb     = 1'b1;
      ST_DONE:   ctl.emit   = out_free;
      default:   in_ready   = 1'b0;
    endcase
  end

endmodule

### sv/biquad_cascade_bandpass_filter_core.sv
// Top level: three-section direct-form-II band-pass biquad cascade on 12-bit samples.
// One sample is processed at a time; each section runs three passes through the shared 17x32
// multiplier, a sum, and a write-back of its delay memory row.
// Reset: coefficients and gains return to defaults, all section delays read as zero,
// the output register empties. A waiting result does not block the next input transaction.
module biquad_cascade_bandpass_filter_core import bqc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bqc_in_if.sink       in_ch,
  bqc_out_if.source    out_ch,
  input  logic         cfg_we,
  input  reg_idx_t     cfg_addr,
  input  coef_t        cfg_wdata
);

  bqc_ctl_t   ctl;
  logic       in_ready;
  logic       out_free;

  coef_t      cfg_r [REG_COUNT];
  coef_kind_e coef_kind;
  coef_t      coef;
  logic signed [COEF_W:0] op_a;
  state_t     op_b;
  prod_t      prod_full;
  prod_t      prod_r;
  acc_t       prod_ext;
  acc_t       acc_r;
  acc_t       acc_fin;
  w0_wide_t   w0_wide;
  state_t     w0_r;
  state_t     w1_r;
  state_t     w2_r;
  state_t     x_r;
  diff_t      y_diff;
  state_t     y_sat;
  logic       clip_r;

  state_t     code_full;
  logic       code_neg;
  logic       code_big;
  sample_t    code;

  logic       rd_en;
  sec_t       rd_addr;
  delay_row_t rd_data;
  delay_row_t wr_data;

  logic       out_valid_r;
  sample_t    out_code_r;
  logic       out_clip_r;

  bqc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  assign in_ch.ready = in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        cfg_r[i] <= reg_reset(reg_idx_t'(i));
      end
    end else if (cfg_we) begin
      cfg_r[cfg_addr] <= cfg_wdata;
    end
  end

  assign rd_en   = ctl.start || (ctl.wb && !ctl.last);
  assign rd_addr = ctl.start ? '0 : sec_t'(ctl.sec + 1'b1);
  assign wr_data = '{w1: w0_r, w2: w1_r};

  bqc_delay_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (ctl.wb),
    .wr_addr (ctl.sec),
    .wr_data (wr_data)
  );

  always_comb begin
    if (ctl.mul_g) begin
      coef_kind = COEF_GAIN;
    end else if (ctl.mul_a1) begin
      coef_kind = COEF_A1;
    end else begin
      coef_kind = COEF_A2;
    end
  end

  assign coef = cfg_r[coef_index(ctl.sec, coef_kind)];
  assign op_a = ctl.mul_g ? {1'b0, coef} : {coef[COEF_W-1], coef};
  assign op_b = ctl.mul_g ? x_r : (ctl.mul_a1 ? w1_r : w2_r);

  assign prod_full = prod_t'(op_a) * prod_t'(op_b);
  assign prod_ext  = acc_t'(prod_r);
  assign acc_fin   = acc_r - (prod_ext <<< 2);
  assign w0_wide   = acc_fin[ACC_W-1:ROUND_SH];
  assign y_diff    = diff_t'(w0_r) - diff_t'(w2_r);
  assign y_sat     = sat_diff(y_diff);

  always_ff @(posedge clk) begin
    if (ctl.mul_g || ctl.mul_a1 || ctl.mul_a2) begin
      prod_r <= prod_full;
    end
    if (ctl.mul_g) begin
      w1_r <= rd_data.w1;
      w2_r <= rd_data.w2;
    end
    if (ctl.mul_a1) begin
      acc_r <= prod_ext + ACC_HALF;
    end else if (ctl.mul_a2) begin
      acc_r <= acc_fin;
    end
    if (ctl.sum) begin
      w0_r <= sat_w0(w0_wide);
    end
    if (ctl.start) begin
      x_r <= state_t'({in_ch.adc_sample, {FRAC_W{1'b0}}});
    end else if (ctl.wb) begin
      x_r <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
    end else if (ctl.start) begin
      clip_r <= 1'b0;
    end else if (ctl.sum) begin
      clip_r <= clip_r || ovf_w0(w0_wide);
    end else if (ctl.wb) begin
      clip_r <= clip_r || ovf_diff(y_diff);
    end
  end

  assign code_full = x_r >>> FRAC_W;
  assign code_neg  = code_full < 0;
  assign code_big  = code_full > state_t'(DAC_MAX);

  always_comb begin
    if (code_neg) begin
      code = '0;
    end else if (code_big) begin
      code = sample_t'(DAC_MAX);
    end else begin
      code = code_full[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_code_r <= code;
      out_clip_r <= clip_r || code_neg || code_big;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.dac_code = out_code_r;
  assign out_ch.clipped  = out_clip_r;

endmodule

### sv/bqc_checker.sv
// Checker: port-level timing properties of the biquad cascade, bound to the top level.
module bqc_checker import bqc_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_dac_code,
  input logic    out_clipped
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dac_code) && $stable(out_clipped))
    else $error("output transaction changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after input");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind biquad_cascade_bandpass_filter_core bqc_checker u_bqc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_dac_code (out_ch.dac_code),
  .out_clipped  (out_ch.clipped)
);
